FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SME_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define SME_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define SME_ASSERT(lbl, clk, rst_n, prop)

`define SME_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

FILE: rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// shared types and constants of the stack machine executor
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_PRINT = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_PRINTED   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_HALTED    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_UP,
    CELL_FROM_DOWN
  } cell_cmd_e;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } exec_state_e;

endpackage

`default_nettype wire

FILE: rtl/sme_if.sv
// ----------------------------------------------------------------------------
// sme_if
// valid/ready channels for instructions and results
// ----------------------------------------------------------------------------
`default_nettype none

interface sme_in_if;
  import sme_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [DATA_W-1:0] immediate;
  logic                    program_start;

  modport source (output valid, output op, output immediate, output program_start,
                  input ready);
  modport sink   (input valid, input op, input immediate, input program_start,
                  output ready);
endinterface

interface sme_out_if;
  import sme_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] print_value;

  modport source (output valid, output status, output print_value, input ready);
  modport sink   (input valid, input status, input print_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// push, add, sub, mul, print: result registered in the cycle after the item is taken
// divide: no new item is taken until the quotient is back from the one-bit-per-cycle divider loop
// async reset empties the stack, clears halted; entries hold no reset value
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stack_machine_executor_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sme_in_if.sink    in_i,
  sme_out_if.source out_o
);
  import sme_pkg::*;

  exec_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              halted_q, halted_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q;
  word_t             pval_q;

  logic              in_fire;
  logic [CNT_W-1:0]  cnt_eff;
  logic              halt_eff;
  cell_cmd_e         top_cmd, rest_cmd;
  word_t             top_val;
  word_t             alu;
  word_t             op_a, op_b;
  logic              res_valid;
  status_e           res_status;
  word_t             res_value;
  logic              div_start;
  logic              div_done;
  word_t             div_quo;

  word_t             cell_q [STACK_DEPTH];

  // stack as a shift chain, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t up_w, down_w;
    if (i == 0) begin : g_top
      assign up_w = top_val;
    end else begin : g_mid
      assign up_w = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_w = cell_q[i];
    end else begin : g_inner
      assign down_w = cell_q[i+1];
    end
    sme_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  ((i == 0) ? top_cmd : rest_cmd),
      .up_i   (up_w),
      .down_i (down_w),
      .data_o (cell_q[i])
    );
  end

  sme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (op_a),
    .divisor_i  (op_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign op_b     = cell_q[0];
  assign op_a     = cell_q[1];
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire  = in_i.valid && in_i.ready;
  assign cnt_eff  = in_i.program_start ? '0 : count_q;
  assign halt_eff = in_i.program_start ? 1'b0 : halted_q;

  always_comb begin
    case (op_e'(in_i.op))
      OP_ADD:  alu = op_a + op_b;
      OP_SUB:  alu = op_a - op_b;
      default: alu = op_a * op_b;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    halted_d   = halted_q;
    top_cmd    = CELL_HOLD;
    rest_cmd   = CELL_HOLD;
    top_val    = word_t'(in_i.immediate);
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    div_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          count_d   = cnt_eff;
          halted_d  = halt_eff;
          res_valid = 1'b1;
          if (halt_eff) begin
            res_status = ST_HALTED;
          end else begin
            case (op_e'(in_i.op))
              OP_PUSH: begin
                if (cnt_eff >= STACK_FULL) begin
                  res_status = ST_OVERFLOW;
                  halted_d   = 1'b1;
                end else begin
                  top_cmd  = CELL_FROM_UP;
                  rest_cmd = CELL_FROM_UP;
                  count_d  = cnt_eff + 1'b1;
                end
              end
              OP_ADD, OP_SUB, OP_MUL: begin
                if (cnt_eff < CNT_W'(2)) begin
                  res_status = ST_UNDERFLOW;
                  halted_d   = 1'b1;
                end else begin
                  top_cmd  = CELL_FROM_UP;
                  top_val  = alu;
                  rest_cmd = CELL_FROM_DOWN;
                  count_d  = cnt_eff - 1'b1;
                end
              end
              OP_DIV: begin
                if (cnt_eff < CNT_W'(2)) begin
                  res_status = ST_UNDERFLOW;
                  halted_d   = 1'b1;
                end else if (op_b == '0) begin
                  res_status = ST_DIVZERO;
                  halted_d   = 1'b1;
                end else begin
                  res_valid = 1'b0;
                  div_start = 1'b1;
                  state_d   = S_DIV;
                end
              end
              OP_PRINT: begin
                if (cnt_eff == '0) begin
                  res_status = ST_EMPTY;
                  halted_d   = 1'b1;
                end else begin
                  top_cmd    = CELL_FROM_DOWN;
                  rest_cmd   = CELL_FROM_DOWN;
                  count_d    = cnt_eff - 1'b1;
                  res_status = ST_PRINTED;
                  res_value  = op_b;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          top_cmd   = CELL_FROM_UP;
          top_val   = div_quo;
          rest_cmd  = CELL_FROM_DOWN;
          count_d   = count_q - 1'b1;
          res_valid = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      status_q <= res_status;
      pval_q   <= res_value;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.print_value = pval_q;

  `SME_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= STACK_FULL)
  `SME_ASSERT_NEXT(a_halted_item, clk_i, rst_ni, in_fire && halted_q && !in_i.program_start, out_valid_q && status_q == ST_HALTED)
  `SME_ASSERT(a_div_done_state, clk_i, rst_ni, div_done |-> state_q == S_DIV)

endmodule

`default_nettype wire

FILE: rtl/sme_cell.sv
// ----------------------------------------------------------------------------
// sme_cell
// one stack entry, shifts toward or away from the top of stack
// ----------------------------------------------------------------------------
`default_nettype none

module sme_cell (
  input  wire logic              clk_i,
  input  sme_pkg::cell_cmd_e     cmd_i,
  input  sme_pkg::word_t         up_i,
  input  sme_pkg::word_t         down_i,
  output sme_pkg::word_t         data_o
);
  import sme_pkg::*;

  word_t data_q;
  word_t data_d;

  always_comb begin
    case (cmd_i)
      CELL_FROM_UP:   data_d = up_i;
      CELL_FROM_DOWN: data_d = down_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/sme_div.sv
// ----------------------------------------------------------------------------
// sme_div
// signed divider truncating toward zero, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sme_div (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  sme_pkg::word_t dividend_i,
  input  sme_pkg::word_t divisor_i,
  output logic           done_o,
  output sme_pkg::word_t quotient_o
);
  import sme_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W:0]      rem_q, rem_d;
  word_t                quo_q, quo_d;
  word_t                mb_q, mb_d;
  logic                 neg_q, neg_d;

  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;
  logic                 na, nb;

  assign na     = dividend_i[DATA_W-1];
  assign nb     = divisor_i[DATA_W-1];
  assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, mb_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = na ? (word_t'(0) - dividend_i) : dividend_i;
      mb_d   = nb ? (word_t'(0) - divisor_i) : divisor_i;
      neg_d  = na ^ nb;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_d = diff;
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (word_t'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire
